### rtl/gcps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcps_pkg
// Shared widths, register map and constant tables of the gamma curve sampler.
// ----------------------------------------------------------------------------
package gcps_pkg;

    localparam int IDX_W  = 11;   // sample index and step count
    localparam int CRD_W  = 17;   // Q1.16 coordinates
    localparam int GAM_W  = 16;   // Q8.8 exponent
    localparam int FRAC_W = 16;   // fraction bits of log and exp
    localparam int MANT_W = 31;   // Q1.30 mantissa
    localparam int REM_W  = 28;   // dividend of the x interpolation
    localparam int DEN_W  = 27;   // shifted divisor
    localparam int LOG_W  = 20;   // log difference, Q4.16
    localparam int MAX_STEPS = 1024;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_START_X   = 3'd0;
    localparam logic [2:0] REG_START_Y   = 3'd1;
    localparam logic [2:0] REG_END_X     = 3'd2;
    localparam logic [2:0] REG_END_Y     = 3'd3;
    localparam logic [2:0] REG_GAMMA     = 3'd4;
    localparam logic [2:0] REG_NUM_STEPS = 3'd5;

    typedef struct packed {
        logic               zero;
        logic               clamped;
        logic [IDX_W-1:0]   j;
        logic [IDX_W-1:0]   n;
        logic [3:0]         bn;
        logic [3:0]         bj;
        logic [CRD_W-1:0]   x;
        logic               big;
        logic [4:0]         k;
        logic [FRAC_W-1:0]  f;
        logic [CRD_W-1:0]   p;
    } t_meta;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // c_i = 2^(-2^-i) in Q1.30, i = 1..16, packed with c_1 at the bottom
    function automatic logic [16*MANT_W-1:0] calc_exp_coefs();
        logic [16*MANT_W-1:0] t;
        logic [63:0]          c;
        t = '0;
        c = isqrt64(64'd1 << 59);
        for (int i = 0; i < 16; i++) begin
            t[i*MANT_W +: MANT_W] = c[MANT_W-1:0];
            c = isqrt64(c << 30);
        end
        return t;
    endfunction

    localparam logic [16*MANT_W-1:0] EXP_COEFS = calc_exp_coefs();

    function automatic logic [3:0] lead_pos(input logic [IDX_W-1:0] v);
        logic [3:0] lp;
        lp = '0;
        for (int i = 0; i < IDX_W; i++) begin
            if (v[i]) lp = 4'(i);
        end
        return lp;
    endfunction

endpackage
`default_nettype wire

### rtl/gcps_log_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcps_log_step
// One squaring step of the log2 fraction: yields one fraction bit per stage.
// ----------------------------------------------------------------------------
module gcps_log_step
    import gcps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [MANT_W-1:0] i_mant,
    input  wire logic [FRAC_W-1:0] i_frac,
    output logic      [MANT_W-1:0] o_mant,
    output logic      [FRAC_W-1:0] o_frac
);

    logic [MANT_W-1:0] r_mant, n_mant;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [61:0]       sq;
    logic [31:0]       t;

    always_comb begin
        sq = 62'(i_mant) * 62'(i_mant);
        t  = sq[61:30];
        if (t[31]) begin
            n_mant = t[31:1];
            n_frac = {i_frac[FRAC_W-2:0], 1'b1};
        end else begin
            n_mant = t[MANT_W-1:0];
            n_frac = {i_frac[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant <= n_mant;
            r_frac <= n_frac;
        end
    end

    assign o_mant = r_mant;
    assign o_frac = r_frac;

endmodule
`default_nettype wire

### rtl/gcps_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcps_div_step
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module gcps_div_step
    import gcps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [CRD_W-1:0] i_quot,
    output logic      [REM_W-1:0] o_rem,
    output logic      [DEN_W-1:0] o_den,
    output logic      [CRD_W-1:0] o_quot
);

    logic [REM_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CRD_W-1:0] r_quot, n_quot;

    always_comb begin
        if (i_rem >= REM_W'(i_den)) begin
            n_rem  = i_rem - REM_W'(i_den);
            n_quot = {i_quot[CRD_W-2:0], 1'b1};
        end else begin
            n_rem  = i_rem;
            n_quot = {i_quot[CRD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den >> 1;
            r_quot <= n_quot;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

### rtl/gcps_exp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcps_exp_step
// One step of 2^-f: multiplies by a root-of-two coefficient when the bit is set.
// ----------------------------------------------------------------------------
module gcps_exp_step
    import gcps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_bit,
    input  wire logic [MANT_W-1:0] i_coef,
    input  wire logic [MANT_W-1:0] i_mant,
    output logic      [MANT_W-1:0] o_mant
);

    logic [MANT_W-1:0] r_mant;
    logic [61:0]       prod;

    assign prod = 62'(i_mant) * 62'(i_coef);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant <= i_bit ? prod[60:30] : i_mant;
        end
    end

    assign o_mant = r_mant;

endmodule
`default_nettype wire

### rtl/gamma_curve_point_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gamma_curve_point_sampler
// Returns point j of a gamma-shaped segment between the configured end points.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry a sample index; output channel:
// o_valid / i_stall carry point_x, point_y and index_clamped. A transaction
// completes on a clock edge with valid high and stall low.
// Throughput is one transaction per cycle while the receiver does not stall.
// The pipeline holds the 16 squaring stages of the log2, the 16 multiply
// stages of the exp2 and the bit-per-stage divider for x, which runs beside
// the log stages.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall rises; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the
// register defaults: start (0,0), end (1.0,1.0), gamma 1.0, 64 steps.
// Registers are written over the APB port at byte address 4*index; the
// user must write them only while the pipeline is empty (not enforced).
// ----------------------------------------------------------------------------
module gamma_curve_point_sampler
    import gcps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [IDX_W-1:0]  i_sample_index,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [CRD_W-1:0]  o_point_x,
    output logic      [CRD_W-1:0]  o_point_y,
    output logic                   o_index_clamped
);

    localparam int NS = 39;

    logic [CRD_W-1:0]  r_start_x, r_start_y, r_end_x, r_end_y;
    logic [GAM_W-1:0]  r_gamma;
    logic [IDX_W-1:0]  r_num_steps;
    logic [2:0]        reg_idx;
    logic              en;

    logic              r_v    [0:NS-1];
    t_meta             r_meta [0:NS-1];
    t_meta             n_meta [0:NS-1];

    logic [MANT_W-1:0] mn [0:16];
    logic [MANT_W-1:0] mj [0:16];
    logic [FRAC_W-1:0] fn [0:16];
    logic [FRAC_W-1:0] fj [0:16];
    logic [REM_W-1:0]  rem  [0:17];
    logic [DEN_W-1:0]  den  [0:17];
    logic [CRD_W-1:0]  quot [0:17];
    logic [MANT_W-1:0] em [0:16];

    logic [LOG_W-1:0]  r_l;
    logic [33:0]       r_prod;
    logic [CRD_W-1:0]  r_y;

    logic              dx_neg, dy_neg;
    logic [CRD_W-1:0]  adx, ady;

    // config port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_end_x     <= CRD_W'(65536);
            r_end_y     <= CRD_W'(65536);
            r_gamma     <= GAM_W'(256);
            r_num_steps <= IDX_W'(64);
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_START_X:   r_start_x   <= pwdata[CRD_W-1:0];
                REG_START_Y:   r_start_y   <= pwdata[CRD_W-1:0];
                REG_END_X:     r_end_x     <= pwdata[CRD_W-1:0];
                REG_END_Y:     r_end_y     <= pwdata[CRD_W-1:0];
                REG_GAMMA:     r_gamma     <= pwdata[GAM_W-1:0];
                REG_NUM_STEPS: r_num_steps <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_X:   prdata = 32'(r_start_x);
            REG_START_Y:   prdata = 32'(r_start_y);
            REG_END_X:     prdata = 32'(r_end_x);
            REG_END_Y:     prdata = 32'(r_end_y);
            REG_GAMMA:     prdata = 32'(r_gamma);
            REG_NUM_STEPS: prdata = 32'(r_num_steps);
            default:       prdata = '0;
        endcase
    end

    assign dx_neg = r_end_x < r_start_x;
    assign dy_neg = r_end_y < r_start_y;
    assign adx    = dx_neg ? r_start_x - r_end_x : r_end_x - r_start_x;
    assign ady    = dy_neg ? r_start_y - r_end_y : r_end_y - r_start_y;

    // pipeline advance
    assign en      = !(r_v[NS-1] && i_stall);
    assign o_stall = !en;

    // stage 0: saturate step count and index
    always_comb begin
        logic [IDX_W-1:0] n_eff;
        n_meta[0] = r_meta[0];
        if (r_num_steps == '0) begin
            n_eff = IDX_W'(1);
        end else if (17'(r_num_steps) > 17'(MAX_STEPS)) begin
            n_eff = IDX_W'(MAX_STEPS);
        end else begin
            n_eff = r_num_steps;
        end
        n_meta[0].n = n_eff;
        if (i_sample_index > n_eff) begin
            n_meta[0].j       = n_eff;
            n_meta[0].clamped = 1'b1;
        end else begin
            n_meta[0].j       = i_sample_index;
            n_meta[0].clamped = 1'b0;
        end
        n_meta[0].zero = (n_meta[0].j == '0);
    end

    // remaining stages copy the side data, a few stages fill in fields
    for (genvar s = 1; s < NS; s++) begin : g_meta
        always_comb begin
            n_meta[s] = r_meta[s-1];
            if (s == 1) begin
                n_meta[s].bn = lead_pos(r_meta[s-1].n);
                n_meta[s].bj = lead_pos(r_meta[s-1].j);
            end else if (s == 19) begin
                logic [35:0] e_full;
                logic [11:0] k;
                e_full = 36'(r_gamma) * 36'(r_l) + 36'd128;
                k = e_full[35:24];
                n_meta[s].f   = e_full[23:8];
                n_meta[s].k   = k[4:0];
                n_meta[s].big = (k >= 12'd17);
                n_meta[s].x   = dx_neg ? r_start_x - quot[17] : r_start_x + quot[17];
            end else if (s == 36) begin
                logic [4:0]  sh;
                logic [31:0] rnd;
                sh  = 5'd14 + r_meta[s-1].k;
                rnd = (32'(em[16]) + (32'd1 << (sh - 5'd1))) >> sh;
                if (r_meta[s-1].zero) begin
                    n_meta[s].p = (r_gamma == '0) ? CRD_W'(65536) : '0;
                end else if (r_meta[s-1].big) begin
                    n_meta[s].p = '0;
                end else begin
                    n_meta[s].p = rnd[CRD_W-1:0];
                end
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en) begin
                r_v[s] <= (s == 0) ? i_valid : r_v[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_meta[s] <= n_meta[s];
            end
        end
    end

    // stage 1: normalized mantissas and the x dividend
    always_ff @(posedge i_clk) begin
        if (en) begin
            mn[0]   <= MANT_W'(r_meta[0].n) << (5'd30 - 5'(lead_pos(r_meta[0].n)));
            mj[0]   <= MANT_W'(r_meta[0].j) << (5'd30 - 5'(lead_pos(r_meta[0].j)));
            fn[0]   <= '0;
            fj[0]   <= '0;
            rem[0]  <= REM_W'(r_meta[0].j) * REM_W'(adx) + REM_W'(r_meta[0].n >> 1);
            den[0]  <= DEN_W'(r_meta[0].n) << 16;
            quot[0] <= '0;
        end
    end

    // stages 2..17: log2 fraction bits; stages 2..18: quotient bits
    for (genvar k = 1; k <= 16; k++) begin : g_log
        gcps_log_step u_log_n (
            .i_clk (i_clk), .i_en (en),
            .i_mant (mn[k-1]), .i_frac (fn[k-1]),
            .o_mant (mn[k]),   .o_frac (fn[k])
        );
        gcps_log_step u_log_j (
            .i_clk (i_clk), .i_en (en),
            .i_mant (mj[k-1]), .i_frac (fj[k-1]),
            .o_mant (mj[k]),   .o_frac (fj[k])
        );
    end

    for (genvar k = 1; k <= 17; k++) begin : g_div
        gcps_div_step u_div (
            .i_clk  (i_clk), .i_en (en),
            .i_rem  (rem[k-1]), .i_den (den[k-1]), .i_quot (quot[k-1]),
            .o_rem  (rem[k]),   .o_den (den[k]),   .o_quot (quot[k])
        );
    end

    // stage 18: log2(n) - log2(j)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l <= {r_meta[17].bn, fn[16]} - {r_meta[17].bj, fj[16]};
        end
    end

    // stages 20..35: 2^-f
    assign em[0] = MANT_W'(1) << 30;

    for (genvar i = 1; i <= 16; i++) begin : g_exp
        gcps_exp_step u_exp (
            .i_clk  (i_clk), .i_en (en),
            .i_bit  (r_meta[18+i].f[16-i]),
            .i_coef (EXP_COEFS[(i-1)*MANT_W +: MANT_W]),
            .i_mant (em[i-1]),
            .o_mant (em[i])
        );
    end

    // stages 37 and 38: scale the y span
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 34'(r_meta[36].p) * 34'(ady);
        end
    end

    always_ff @(posedge i_clk) begin
        logic [33:0] q;
        q = (r_prod + 34'd32768) >> 16;
        if (en) begin
            r_y <= dy_neg ? r_start_y - q[CRD_W-1:0] : r_start_y + q[CRD_W-1:0];
        end
    end

    assign o_valid         = r_v[NS-1];
    assign o_point_x       = r_meta[NS-1].x;
    assign o_point_y       = r_y;
    assign o_index_clamped = r_meta[NS-1].clamped;

endmodule
`default_nettype wire

### bench/gamma_curve_point_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_curve_point_sampler_tb
// Sends sample indexes under segment settings written over APB while the
// pipeline is empty, checks each point against a fixed-point curve predictor
// in the bench or a typed point. Both channels idle at random except in phase 6.
// ----------------------------------------------------------------------------
module gamma_curve_point_sampler_tb
    import gcps_pkg::*;
();

    localparam logic [2:0] REG_NONE = 3'd6;   // no register behind this slot
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic             c;
    } t_point;

    typedef struct {
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_point           pt;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid;
    logic              o_stall;
    logic [IDX_W-1:0]  i_sample_index;
    logic              o_valid;
    logic              i_stall;
    logic [CRD_W-1:0]  o_point_x;
    logic [CRD_W-1:0]  o_point_y;
    logic              o_index_clamped;

    gamma_curve_point_sampler DUT (.*);

    // bench copy of the segment settings
    logic [CRD_W-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic [GAM_W-1:0] seg_gamma;
    logic [IDX_W-1:0] seg_steps;

    longint unsigned exp_coef [1:16];
    t_point          pending_points [$];
    int              errors;
    int              stall_left;
    bit              no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("gamma_curve_point_sampler_tb: FAIL");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned log2_q16(longint unsigned v);
        int              top;
        longint unsigned m, fr;
        top = 0;
        fr = 0;
        while ((v >> (top + 1)) != 0) top++;
        m = v << (30 - top);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd2 << 30)) begin
                fr = fr | 1;
                m = m >> 1;
            end
        end
        return (longint'(top) << 16) | (fr & 16'hFFFF);
    endfunction

    function automatic longint unsigned pow2_neg(longint unsigned e);
        longint unsigned k, f, m;
        int              s;
        k = e >> 16;
        f = e & 16'hFFFF;
        m = 64'd1 << 30;
        if (k >= 17) return 0;
        for (int i = 1; i <= 16; i++)
            if ((f >> (16 - i)) & 1) m = (m * exp_coef[i]) >> 30;
        s = 14 + int'(k);
        return (m + (64'd1 << (s - 1))) >> s;
    endfunction

    // halves away from zero
    function automatic longint round_div(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic t_point curve_point(logic [IDX_W-1:0] idx);
        t_point          r;
        longint unsigned n, j, p, l, e;
        longint          dx, dy;
        n = seg_steps;
        j = idx;
        r.c = 1'b0;
        if (n == 0) n = 1;
        if (n > MAX_STEPS) n = MAX_STEPS;
        if (j > n) begin
            j = n;
            r.c = 1'b1;
        end
        if (j == 0) begin
            p = (seg_gamma == 0) ? 65536 : 0;
        end else begin
            l = log2_q16(n) - log2_q16(j);
            e = (longint'(seg_gamma) * l + 128) >> 8;
            p = pow2_neg(e);
        end
        dx = longint'(seg_ex) - longint'(seg_sx);
        dy = longint'(seg_ey) - longint'(seg_sy);
        r.x = CRD_W'(longint'(seg_sx) + round_div(longint'(j) * dx, longint'(n)));
        r.y = CRD_W'(longint'(seg_sy) + round_div(longint'(p) * dy, 65536));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_START_X:   seg_sx = val[CRD_W-1:0];
            REG_START_Y:   seg_sy = val[CRD_W-1:0];
            REG_END_X:     seg_ex = val[CRD_W-1:0];
            REG_END_Y:     seg_ey = val[CRD_W-1:0];
            REG_GAMMA:     seg_gamma = val[GAM_W-1:0];
            REG_NUM_STEPS: seg_steps = val[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_segment(int sx, int sy, int ex, int ey, int g, int n);
        reg_write(REG_START_X, sx);
        reg_write(REG_START_Y, sy);
        reg_write(REG_END_X, ex);
        reg_write(REG_END_Y, ey);
        reg_write(REG_GAMMA, g);
        reg_write(REG_NUM_STEPS, n);
    endtask

    task automatic send_index(logic [IDX_W-1:0] idx, bit typed, t_point pt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_index <= idx;
        do @(posedge i_clk); while (o_stall);
        pending_points.push_back(typed ? pt : curve_point(idx));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int n;
        n = (seg_steps == 0) ? 1 : (seg_steps > MAX_STEPS ? MAX_STEPS : seg_steps);
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom);
            1: return IDX_W'(n + $urandom_range(1, 4));
            2: return IDX_W'($urandom_range(0, 1) ? 0 : n);
            default: return IDX_W'($urandom_range(0, n));
        endcase
    endfunction

    // result side: random stall run before each result, checks in order
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left <= no_idle ? 0 : $urandom_range(0, 7);
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result transaction point_x", o_point_x, 0);
            end else begin
                want = pending_points.pop_front();
                if (o_point_x !== want.x) report_mismatch("point_x", o_point_x, want.x);
                if (o_point_y !== want.y) report_mismatch("point_y", o_point_y, want.y);
                if (o_index_clamped !== want.c)
                    report_mismatch("index_clamped", o_index_clamped, want.c);
            end
        end
    end

    t_row directed [] = '{
        '{11'd0,    1, '{17'd0,     17'd0,     1'b0}},
        '{11'd64,   1, '{17'd65536, 17'd65536, 1'b0}},
        '{11'd32,   1, '{17'd32768, 17'd32768, 1'b0}},
        '{11'd2047, 1, '{17'd65536, 17'd65536, 1'b1}},
        '{11'd65,   1, '{17'd65536, 17'd65536, 1'b1}},
        '{11'd1,    0, '{0, 0, 0}},
        '{11'd63,   0, '{0, 0, 0}},
        '{11'd1024, 0, '{0, 0, 0}},
        '{11'd1365, 0, '{0, 0, 0}},
        '{11'd682,  0, '{0, 0, 0}},
        '{11'd17,   0, '{0, 0, 0}},
        '{11'd48,   0, '{0, 0, 0}}
    };

    initial begin
        longint unsigned c;
        c = int_sqrt(64'd1 << 59);
        for (int i = 1; i <= 16; i++) begin
            exp_coef[i] = c;
            c = int_sqrt(c << 30);
        end
        errors = 0;
        stall_left = 0;
        no_idle = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_sample_index = '0;
        seg_sx = 0;
        seg_sy = 0;
        seg_ex = 65536;
        seg_ey = 65536;
        seg_gamma = 256;
        seg_steps = 64;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults after reset
        foreach (directed[r]) send_index(directed[r].idx, directed[r].typed, directed[r].pt);
        wait_idle();

        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0: load_segment(0, 0, 65536, 65536, 0, 1);            // gamma zero
                1: load_segment(65536, 65536, 0, 0, 65535, 1024);     // falling, steep
                2: load_segment(1000, 2000, 3000, 500, 128, 0);       // step count zero
                3: load_segment(131071, 0, 0, 131071, 512, 2047);     // past range
                default: load_segment($urandom_range(0, 65536), $urandom_range(0, 65536),
                                      $urandom_range(0, 65536), $urandom_range(0, 65536),
                                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 1024),
                                      $urandom_range(0, 3) == 0 ? $urandom_range(1, 1024)
                                                                : $urandom_range(1, 64));
            endcase
            if (ph == 5) reg_write(REG_NONE, $urandom);
            no_idle = (ph == 6);
            for (int k = 0; k < 90; k++) send_index(pick_index(), 0, '{0, 0, 0});
            wait_idle();
        end

        if (errors == 0) begin
            $display("gamma_curve_point_sampler_tb: PASS");
        end else begin
            $display("gamma_curve_point_sampler_tb: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/gcps_pkg.sv
rtl/gcps_log_step.sv
rtl/gcps_div_step.sv
rtl/gcps_exp_step.sv
rtl/gamma_curve_point_sampler.sv
bench/gamma_curve_point_sampler_tb.sv
